@@ sv/lts_pkg.sv @@
// ----------------------------------------------------------------------------
// lts_pkg: shared types and constants of the s-expression token scanner
// Record kinds, scan modes, character codes and the record bundle that
// carries up to three result records of one source item.
// ----------------------------------------------------------------------------
package lts_pkg;

	// default widths of the position counters
	localparam int LINE_BITS_DEF   = 16;
	localparam int COLUMN_BITS_DEF = 16;

	// records produced by one item at most
	localparam int MAX_RECS = 3;

	// record kinds
	typedef enum logic [2:0] {
		K_CHAR   = 3'd0,
		K_LPAREN = 3'd1,
		K_RPAREN = 3'd2,
		K_NUMBER = 3'd3,
		K_SYMBOL = 3'd4,
		K_STRING = 3'd5,
		K_ERROR  = 3'd6,
		K_EOF    = 3'd7
	} kind_t;

	// scanner modes
	typedef enum logic [2:0] {
		M_IDLE    = 3'd0,
		M_NUM     = 3'd1,
		M_NUM_DOT = 3'd2,
		M_SYM     = 3'd3,
		M_STR     = 3'd4,
		M_STR_ESC = 3'd5
	} mode_t;

	// character codes
	localparam logic [7:0] CH_LPAREN    = 8'h28;
	localparam logic [7:0] CH_RPAREN    = 8'h29;
	localparam logic [7:0] CH_DOT       = 8'h2E;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_T         = 8'h74;
	localparam logic [7:0] CH_N         = 8'h6E;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;

	// one source item
	typedef struct packed {
		logic [7:0] byte_in;
		logic       end_mark;
	} item_t;

	// registered input item with its valid flag
	typedef struct packed {
		logic  valid;
		item_t item;
	} stage_t;

	// one result record, last flag added on output
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  char_out;
		logic [15:0] start_line;
		logic [15:0] start_column;
	} rec_t;

	// all records of one item
	typedef struct packed {
		rec_t [MAX_RECS-1:0] rec;
		logic [1:0]          count;
	} bundle_t;

endpackage

@@ sv/lts_if.sv @@
// ----------------------------------------------------------------------------
// lts_if: stream channels of the token scanner
// Valid/ready channels for source items and for result records.
// ----------------------------------------------------------------------------

// source item channel
interface lts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       end_mark;

	modport source (output valid, output byte_in, output end_mark, input ready);
	modport sink   (input valid, input byte_in, input end_mark, output ready);
endinterface

// result record channel
interface lts_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  char_out;
	logic [15:0] start_line;
	logic [15:0] start_column;
	logic        last;

	modport source (output valid, output kind, output char_out, output start_line,
		output start_column, output last, input ready);
	modport sink   (input valid, input kind, input char_out, input start_line,
		input start_column, input last, output ready);
endinterface

@@ sv/lts_in_stage.sv @@
// ----------------------------------------------------------------------------
// lts_in_stage: input register of the token scanner
// Holds one source item until the lexer stage takes it.
// ----------------------------------------------------------------------------
module lts_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	lts_in_if.sink          src,
	input  logic            advance,
	output lts_pkg::stage_t s1
);

	logic                  valid_s1;
	lts_pkg::item_t        item_s1;

	// free when empty or when the held item moves on this cycle
	assign src.ready = !valid_s1 || advance;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src.ready) begin
			valid_s1 <= src.valid;
		end
	end

	// payload on transfer
	always_ff @(posedge clk) begin
		if (src.valid && src.ready) begin
			item_s1.byte_in  <= src.byte_in;
			item_s1.end_mark <= src.end_mark;
		end
	end

	assign s1.valid = valid_s1;
	assign s1.item  = item_s1;

endmodule

@@ sv/lts_lexer.sv @@
// ----------------------------------------------------------------------------
// lts_lexer: scanner state and record generation
// Decodes one item against the scan mode, builds its records and updates
// the mode and the line and column counters.
// ----------------------------------------------------------------------------
module lts_lexer #(
	parameter int LINE_BITS   = lts_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = lts_pkg::COLUMN_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  lts_pkg::item_t   item,
	output lts_pkg::bundle_t res
);

	lts_pkg::mode_t         mode_q, mode_d;
	logic [LINE_BITS-1:0]   cur_line_q, tok_line_q, tok_line_d;
	logic [COLUMN_BITS-1:0] cur_col_q, tok_col_q, tok_col_d;
	logic [7:0]             c;
	logic                   eof;

	assign c   = item.byte_in;
	assign eof = item.end_mark;

	function automatic logic is_space(logic [7:0] ch);
		return ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D);
	endfunction

	function automatic logic is_num(logic [7:0] ch);
		return (ch >= 8'h30 && ch <= 8'h39) || ch == lts_pkg::CH_DOT;
	endfunction

	function automatic logic is_sym(logic [7:0] ch);
		return (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A) ||
			ch == 8'h2B || ch == 8'h2D || ch == 8'h2A || ch == 8'h2F ||
			ch == 8'h3C || ch == 8'h3E || ch == 8'h3D;
	endfunction

	function automatic lts_pkg::rec_t mk(lts_pkg::kind_t k, logic [7:0] ch,
		logic [LINE_BITS-1:0] l, logic [COLUMN_BITS-1:0] col);
		lts_pkg::rec_t r;
		r.kind         = k;
		r.char_out     = ch;
		r.start_line   = 16'(l);
		r.start_column = 16'(col);
		return r;
	endfunction

	// record generation and next mode
	always_comb begin
		logic [1:0] n;
		logic       reproc;
		logic       ok;
		logic [7:0] d;
		n          = 2'd0;
		reproc     = 1'b0;
		ok         = 1'b0;
		d          = 8'd0;
		res        = '0;
		mode_d     = mode_q;
		tok_line_d = tok_line_q;
		tok_col_d  = tok_col_q;

		unique case (mode_q)
			lts_pkg::M_NUM, lts_pkg::M_NUM_DOT: begin
				if (!eof && is_num(c)) begin
					res.rec[n] = mk(lts_pkg::K_CHAR, c, tok_line_q, tok_col_q);
					n = n + 2'd1;
					if (c == lts_pkg::CH_DOT) begin
						if (mode_q == lts_pkg::M_NUM_DOT) begin
							res.rec[n] = mk(lts_pkg::K_ERROR, 8'd0, tok_line_q, tok_col_q);
							n = n + 2'd1;
							mode_d = lts_pkg::M_IDLE;
						end else begin
							mode_d = lts_pkg::M_NUM_DOT;
						end
					end
				end else begin
					res.rec[n] = mk(lts_pkg::K_NUMBER, 8'd0, tok_line_q, tok_col_q);
					n = n + 2'd1;
					mode_d = lts_pkg::M_IDLE;
					reproc = 1'b1;
				end
			end
			lts_pkg::M_SYM: begin
				if (!eof && is_sym(c)) begin
					res.rec[n] = mk(lts_pkg::K_CHAR, c, tok_line_q, tok_col_q);
					n = n + 2'd1;
				end else begin
					res.rec[n] = mk(lts_pkg::K_SYMBOL, 8'd0, tok_line_q, tok_col_q);
					n = n + 2'd1;
					mode_d = lts_pkg::M_IDLE;
					reproc = 1'b1;
				end
			end
			lts_pkg::M_STR: begin
				if (eof || c == lts_pkg::CH_NEWLINE) begin
					res.rec[n] = mk(lts_pkg::K_ERROR, 8'd0, tok_line_q, tok_col_q);
					n = n + 2'd1;
					mode_d = lts_pkg::M_IDLE;
				end else if (c == lts_pkg::CH_QUOTE) begin
					res.rec[n] = mk(lts_pkg::K_STRING, 8'd0, tok_line_q, tok_col_q);
					n = n + 2'd1;
					mode_d = lts_pkg::M_IDLE;
				end else if (c == lts_pkg::CH_BACKSLASH) begin
					mode_d = lts_pkg::M_STR_ESC;
				end else begin
					res.rec[n] = mk(lts_pkg::K_CHAR, c, tok_line_q, tok_col_q);
					n = n + 2'd1;
				end
			end
			lts_pkg::M_STR_ESC: begin
				// escape decode
				if (!eof) begin
					if (c == lts_pkg::CH_T) begin
						ok = 1'b1;
						d  = lts_pkg::CH_TAB;
					end else if (c == lts_pkg::CH_N) begin
						ok = 1'b1;
						d  = lts_pkg::CH_NEWLINE;
					end else if (c == lts_pkg::CH_QUOTE || c == lts_pkg::CH_BACKSLASH) begin
						ok = 1'b1;
						d  = c;
					end
				end
				if (ok) begin
					res.rec[n] = mk(lts_pkg::K_CHAR, d, tok_line_q, tok_col_q);
					n = n + 2'd1;
					mode_d = lts_pkg::M_STR;
				end else begin
					res.rec[n] = mk(lts_pkg::K_ERROR, 8'd0, tok_line_q, tok_col_q);
					n = n + 2'd1;
					mode_d = lts_pkg::M_IDLE;
				end
			end
			lts_pkg::M_IDLE: begin
				reproc = 1'b1;
			end
			default: begin
				mode_d = lts_pkg::M_IDLE;
				reproc = 1'b1;
			end
		endcase

		// byte seen between tokens, also the byte that ended a token
		if (reproc) begin
			if (eof) begin
				res.rec[n] = mk(lts_pkg::K_EOF, 8'd0, cur_line_q, cur_col_q);
				n = n + 2'd1;
			end else if (!is_space(c)) begin
				tok_line_d = cur_line_q;
				tok_col_d  = cur_col_q;
				if (c == lts_pkg::CH_LPAREN) begin
					res.rec[n] = mk(lts_pkg::K_LPAREN, 8'd0, cur_line_q, cur_col_q);
					n = n + 2'd1;
				end else if (c == lts_pkg::CH_RPAREN) begin
					res.rec[n] = mk(lts_pkg::K_RPAREN, 8'd0, cur_line_q, cur_col_q);
					n = n + 2'd1;
				end else if (is_num(c)) begin
					res.rec[n] = mk(lts_pkg::K_CHAR, c, cur_line_q, cur_col_q);
					n = n + 2'd1;
					mode_d = (c == lts_pkg::CH_DOT) ? lts_pkg::M_NUM_DOT : lts_pkg::M_NUM;
				end else if (is_sym(c)) begin
					res.rec[n] = mk(lts_pkg::K_CHAR, c, cur_line_q, cur_col_q);
					n = n + 2'd1;
					mode_d = lts_pkg::M_SYM;
				end else if (c == lts_pkg::CH_QUOTE) begin
					mode_d = lts_pkg::M_STR;
				end else begin
					res.rec[n] = mk(lts_pkg::K_CHAR, c, cur_line_q, cur_col_q);
					n = n + 2'd1;
					res.rec[n] = mk(lts_pkg::K_ERROR, 8'd0, cur_line_q, cur_col_q);
					n = n + 2'd1;
				end
			end
		end
		res.count = n;
	end

	// mode and token start registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= lts_pkg::M_IDLE;
			tok_line_q <= LINE_BITS'(1);
			tok_col_q  <= COLUMN_BITS'(1);
		end else if (advance) begin
			mode_q     <= mode_d;
			tok_line_q <= tok_line_d;
			tok_col_q  <= tok_col_d;
		end
	end

	// saturating position counters, end mark leaves them alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_line_q <= LINE_BITS'(1);
			cur_col_q  <= COLUMN_BITS'(1);
		end else if (advance && !eof) begin
			if (c == lts_pkg::CH_NEWLINE) begin
				if (cur_line_q != '1) begin
					cur_line_q <= cur_line_q + LINE_BITS'(1);
				end
				cur_col_q <= COLUMN_BITS'(1);
			end else if (cur_col_q != '1) begin
				cur_col_q <= cur_col_q + COLUMN_BITS'(1);
			end
		end
	end

endmodule

@@ sv/lts_out_buffer.sv @@
// ----------------------------------------------------------------------------
// lts_out_buffer: result register of the token scanner
// Holds the records of one item and hands them out one per transfer.
// ----------------------------------------------------------------------------
module lts_out_buffer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  lts_pkg::bundle_t res,
	output logic             can_load,
	lts_out_if.source        dst
);

	lts_pkg::bundle_t buf_q;
	logic             valid_q;
	logic [1:0]       idx_q;
	logic             final_w;
	lts_pkg::rec_t    cur;

	assign final_w  = idx_q == 2'(buf_q.count - 2'd1);
	assign can_load = !valid_q || (dst.ready && final_w);

	// record index and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (can_load) begin
			valid_q <= load && (res.count != 2'd0);
			idx_q   <= 2'd0;
		end else if (dst.ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// record payload
	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= res;
		end
	end

	// current record to the channel
	assign cur              = buf_q.rec[idx_q];
	assign dst.valid        = valid_q;
	assign dst.kind         = cur.kind;
	assign dst.char_out     = cur.char_out;
	assign dst.start_line   = cur.start_line;
	assign dst.start_column = cur.start_column;
	assign dst.last         = final_w;

endmodule

@@ sv/lisp_token_scanner_top.sv @@
// ----------------------------------------------------------------------------
// lisp_token_scanner_top: s-expression token scanner
// Channel  Dir  Payload
// in_ch    in   byte_in[7:0], end_mark
// out_ch   out  kind[2:0], char_out[7:0], start_line[15:0], start_column[15:0], last
//
// An item enters the input register, is decoded combinationally as it moves on, and
// its zero to three records land in the result register, which sends one record per
// transfer. An item causing at most one record sustains one item per cycle while the
// output is ready; an item causing k records holds the result register until all k
// are sent. Reset clears the scan mode, puts all positions at line 1 column 1 and
// empties both registers. A stalled output holds the input once both hold.
// ----------------------------------------------------------------------------
module lisp_token_scanner_top #(
	parameter int LINE_BITS   = lts_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = lts_pkg::COLUMN_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	lts_in_if.sink    in_ch,
	lts_out_if.source out_ch
);

	lts_pkg::stage_t  s1;
	lts_pkg::bundle_t res;
	logic             can_load;
	logic             advance;

	// held item moves on once the result register is free
	assign advance = s1.valid && can_load;

	lts_in_stage u_in (
		.clk     (clk),
		.arst_n  (arst_n),
		.src     (in_ch),
		.advance (advance),
		.s1      (s1)
	);

	lts_lexer #(
		.LINE_BITS   (LINE_BITS),
		.COLUMN_BITS (COLUMN_BITS)
	) u_lexer (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (s1.item),
		.res     (res)
	);

	lts_out_buffer u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.res      (res),
		.can_load (can_load),
		.dst      (out_ch)
	);

`ifndef SYNTHESIS
	// a held item stays put until the result register takes it
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1.valid && !advance |=> s1.valid && $stable(s1.item))
		else $error("input item lost while stalled");

	// end of file closes the records of its item
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.kind == lts_pkg::K_EOF |-> out_ch.last)
		else $error("eof record not final");

	// an error closes the records of its item
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.kind == lts_pkg::K_ERROR |-> out_ch.last)
		else $error("error record not final");

	// only lexeme characters carry a character
	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.kind != lts_pkg::K_CHAR |-> out_ch.char_out == 8'd0)
		else $error("token record carries a character");
`endif

endmodule
